// ===== rtl/spg_pkg.sv =====
`default_nettype none
package spg_pkg;

  localparam int unsigned SCRIPT_DEPTH_DEF = 256;

  localparam int unsigned ACTION_W = 2;
  localparam int unsigned DATA_W   = 16;
  localparam int unsigned INDEX_W  = 8;
  localparam int unsigned LEN_W    = 9;
  localparam int unsigned STATE_W  = 32;
  localparam int unsigned COUNT_W  = 32;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  typedef logic [ACTION_W-1:0] action_t;
  typedef logic [STATE_W-1:0]  state_t;
  typedef logic [COUNT_W-1:0]  count_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam action_t ACT_DRAW  = 2'd0;
  localparam action_t ACT_SEED  = 2'd1;
  localparam action_t ACT_WRITE = 2'd2;

  localparam cfg_idx_t CFG_SCRIPT_EN = 3'd0;
  localparam cfg_idx_t CFG_XOR_EN    = 3'd1;
  localparam cfg_idx_t CFG_SCRIPT_LEN = 3'd2;
  localparam cfg_idx_t CFG_LCG_MULT  = 3'd3;
  localparam cfg_idx_t CFG_LCG_INCR  = 3'd4;

  localparam state_t LCG_MULT_RST = 32'd1103515245;
  localparam state_t LCG_INCR_RST = 32'd24691;
  localparam state_t SCRAMBLE_SEED = 32'h9E37_79B9;
  localparam count_t COUNT_MAX = '1;

  function automatic count_t sat_inc(input count_t c);
    sat_inc = (c == COUNT_MAX) ? c : c + count_t'(1);
  endfunction

  // 13/17/5 xorshift; a zero state starts from the scramble constant
  function automatic state_t xorshift_next(input state_t s);
    state_t x;
    x = (s != '0) ? s : SCRAMBLE_SEED;
    x = x ^ (x << 13);
    x = x ^ (x >> 17);
    x = x ^ (x << 5);
    xorshift_next = x;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/scripted_prng_generator_unit.sv =====
`default_nettype none
// 16-bit random value source on a 32-bit generator state. Every item gives
// one result: a draw returns the next value (script table word, LCG or
// xorshift32 step), a seed or script write returns zero value with the
// current counts. One item per cycle is taken unless stalled; its result
// passes stage 1 into the output register. The rate is set by the generator
// state loop: one 32x32 multiply-add (or three xorshift steps) per cycle
// feeding the state register. The script table is a SCRIPT_DEPTH x 16 memory
// with one write and one registered read port, read at accept time, with no
// clearing pass; the user must write an entry before it is read (unchecked).
module scripted_prng_generator_unit #(
  parameter int unsigned SCRIPT_DEPTH = spg_pkg::SCRIPT_DEPTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [spg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [spg_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [spg_pkg::ACTION_W-1:0]    in_action,
  input  wire logic [spg_pkg::DATA_W-1:0]      in_data_word,
  input  wire logic [spg_pkg::INDEX_W-1:0]     in_entry_index,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [spg_pkg::DATA_W-1:0]           out_random_value,
  output logic                                 out_underflowed,
  output logic [spg_pkg::COUNT_W-1:0]          out_draw_count,
  output logic [spg_pkg::COUNT_W-1:0]          out_underflow_count
);
  import spg_pkg::*;

  localparam int unsigned AW = (SCRIPT_DEPTH > 1) ? $clog2(SCRIPT_DEPTH) : 1;

  // configuration
  logic                 script_en_r;
  logic                 xor_en_r;
  logic [LEN_W-1:0]     script_len_r;
  state_t               lcg_mult_r;
  state_t               lcg_incr_r;

  // state
  state_t               gen_state_r, gen_state_nxt;
  logic [LEN_W-1:0]     pos_r;
  count_t               draws_r, draws_nxt;
  count_t               unders_r, unders_nxt;

  // script table
  logic [DATA_W-1:0]    script_mem [SCRIPT_DEPTH];
  logic [DATA_W-1:0]    rd_data_r;

  // stage 1
  logic                 s1_v_r;
  action_t              s1_action_r;
  logic [DATA_W-1:0]    s1_data_r;
  logic                 s1_hit_r;

  // output register
  logic                 out_v_r;
  logic [DATA_W-1:0]    out_value_r, value_nxt;
  logic                 out_under_r, under_nxt;
  count_t               out_draws_r;
  count_t               out_unders_r;

  logic                 out_free, s1_adv, in_acc;
  logic                 hit0, mem_we;
  state_t               lcg_state, xs_state;

  assign out_free = !out_v_r || !out_stall;
  assign s1_adv   = s1_v_r && out_free;
  assign in_stall = s1_v_r && !out_free;
  assign in_acc   = in_valid && !in_stall;

  // a scripted draw takes the next word while pos is below script_len and depth
  assign hit0 = (in_action == ACT_DRAW) && script_en_r && (pos_r < script_len_r)
                && (32'(pos_r) < SCRIPT_DEPTH);
  assign mem_we = in_acc && (in_action == ACT_WRITE)
                  && (32'(in_entry_index) < SCRIPT_DEPTH);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      script_mem[AW'(in_entry_index)] <= in_data_word;
    end
    if (in_acc && hit0) begin
      rd_data_r <= script_mem[AW'(pos_r)];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      script_en_r  <= 1'b0;
      xor_en_r     <= 1'b0;
      script_len_r <= '0;
      lcg_mult_r   <= LCG_MULT_RST;
      lcg_incr_r   <= LCG_INCR_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SCRIPT_EN:  script_en_r  <= cfg_wdata[0];
        CFG_XOR_EN:     xor_en_r     <= cfg_wdata[0];
        CFG_SCRIPT_LEN: script_len_r <= cfg_wdata[LEN_W-1:0];
        CFG_LCG_MULT:   lcg_mult_r   <= cfg_wdata;
        CFG_LCG_INCR:   lcg_incr_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign lcg_state = gen_state_r * lcg_mult_r + lcg_incr_r;
  assign xs_state  = xorshift_next(gen_state_r);

  always_comb begin
    value_nxt     = '0;
    under_nxt     = 1'b0;
    gen_state_nxt = gen_state_r;
    draws_nxt     = draws_r;
    unders_nxt    = unders_r;
    case (s1_action_r)
      ACT_DRAW: begin
        draws_nxt = sat_inc(draws_r);
        if (script_en_r) begin
          if (s1_hit_r) begin
            value_nxt = rd_data_r;
          end else begin
            under_nxt  = 1'b1;
            unders_nxt = sat_inc(unders_r);
            value_nxt  = lcg_state[STATE_W-1:DATA_W];
          end
          gen_state_nxt = {value_nxt, {DATA_W{1'b0}}};
        end else if (xor_en_r) begin
          gen_state_nxt = xs_state;
          value_nxt     = xs_state[STATE_W-1:DATA_W];
        end else begin
          gen_state_nxt = lcg_state;
          value_nxt     = lcg_state[STATE_W-1:DATA_W];
        end
      end
      ACT_SEED: gen_state_nxt = STATE_W'(s1_data_r);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      out_v_r     <= 1'b0;
      pos_r       <= '0;
      gen_state_r <= '0;
      draws_r     <= '0;
      unders_r    <= '0;
    end else begin
      if (in_acc) begin
        s1_v_r <= 1'b1;
      end else if (s1_adv) begin
        s1_v_r <= 1'b0;
      end
      if (s1_adv) begin
        out_v_r <= 1'b1;
      end else if (!out_stall) begin
        out_v_r <= 1'b0;
      end
      // advance the script position at accept so back-to-back draws read in order
      if (in_acc && hit0) begin
        pos_r <= pos_r + LEN_W'(1);
      end
      if (s1_adv) begin
        gen_state_r <= gen_state_nxt;
        draws_r     <= draws_nxt;
        unders_r    <= unders_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_action_r <= in_action;
      s1_data_r   <= in_data_word;
      s1_hit_r    <= hit0;
    end
    if (s1_adv) begin
      out_value_r  <= value_nxt;
      out_under_r  <= under_nxt;
      out_draws_r  <= draws_nxt;
      out_unders_r <= unders_nxt;
    end
  end

  assign out_valid           = out_v_r;
  assign out_random_value    = out_value_r;
  assign out_underflowed     = out_under_r;
  assign out_draw_count      = out_draws_r;
  assign out_underflow_count = out_unders_r;

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_v_r)
    else $error("input stalled with empty stage 1");

  a_draws_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (draws_r >= $past(draws_r)))
    else $error("draw count went backwards");

  a_unders_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    unders_r <= draws_r)
    else $error("underflow count exceeds draw count");

  a_pos_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    32'(pos_r) <= SCRIPT_DEPTH)
    else $error("script position beyond table");

  a_under_counted: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_under_r) |-> (out_unders_r != '0))
    else $error("underflow reported without count");

endmodule
`default_nettype wire
